// File: hw/rtl/dct_coefficient_quantizer_4x4_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the 4x4 coefficient quantizer
// Both macros expect clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef DCT_COEFFICIENT_QUANTIZER_4X4_CORE_ASSERT_SVH
`define DCT_COEFFICIENT_QUANTIZER_4X4_CORE_ASSERT_SVH

// same-cycle implication
`define DCTQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DCTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/dctq_pkg.sv
// ---------------------------------------------------------------------------
// dctq_pkg
// Shared widths, codes, level table and helper functions of the quantizer.
// ---------------------------------------------------------------------------
package dctq_pkg;

	localparam int NPOS        = 16;
	localparam int POS_W       = 4;
	localparam int COEF_W      = 12;
	localparam int RANGE_W     = 11;
	localparam int SHIFT_W     = 7;
	localparam int QUANT_W     = 9;
	localparam int QUAL_W      = 4;
	localparam int STEP_W      = 12;
	localparam int ROW_W       = 3;
	localparam int EXP_W       = 3;
	localparam int DIV_STAGES  = 4;
	localparam int DIV_BITS    = STEP_W / DIV_STAGES;
	localparam int SUM_W       = 14;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUANT = 1'b1;

	localparam logic [QUAL_W-1:0] QUAL_RESET = 4'd1;
	localparam logic signed [SUM_W-1:0] OUT_MAX = 14'sd255;
	localparam logic signed [SUM_W-1:0] OUT_MIN = -14'sd256;
	localparam logic [STEP_W-1:0] DC_SPAN = 12'd1024;

	typedef logic [EXP_W-1:0] lexp_t;

	// log2 of the level count per row and position; zero means no levels
	localparam lexp_t LEVEL_EXP [8][NPOS] = '{
		'{3'd4, 3'd3, 3'd0, 3'd0, 3'd3, 3'd0, 3'd0, 3'd0,
		  3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd5, 3'd3, 3'd0, 3'd0, 3'd3, 3'd0, 3'd0, 3'd0,
		  3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd5, 3'd3, 3'd2, 3'd0, 3'd3, 3'd2, 3'd0, 3'd0,
		  3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd5, 3'd4, 3'd3, 3'd2, 3'd4, 3'd3, 3'd2, 3'd0,
		  3'd3, 3'd2, 3'd0, 3'd0, 3'd2, 3'd0, 3'd0, 3'd0},
		'{3'd5, 3'd4, 3'd3, 3'd2, 3'd4, 3'd3, 3'd2, 3'd2,
		  3'd3, 3'd2, 3'd2, 3'd0, 3'd2, 3'd2, 3'd0, 3'd0},
		'{3'd6, 3'd4, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd2,
		  3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd0},
		'{3'd6, 3'd5, 3'd4, 3'd3, 3'd5, 3'd4, 3'd3, 3'd2,
		  3'd4, 3'd3, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd0},
		'{3'd7, 3'd6, 3'd5, 3'd4, 3'd6, 3'd5, 3'd4, 3'd3,
		  3'd5, 3'd4, 3'd3, 3'd2, 3'd4, 3'd3, 3'd2, 3'd0}
	};

	// stored per position: step and level shift
	typedef struct packed {
		logic [STEP_W-1:0]  step;
		logic [SHIFT_W-1:0] shift;
	} entry_t;

	// side data that rides along the divider
	typedef struct packed {
		logic               neg;
		logic               zero;
		logic [SHIFT_W-1:0] add;
	} div_side_t;

	// partial state of the restoring divider
	typedef struct packed {
		logic [STEP_W-1:0] rem;
		logic [STEP_W-1:0] dvd;
		logic [STEP_W-1:0] quo;
		logic [STEP_W-1:0] dsr;
	} div_state_t;

	// clamp the quality index into a table row
	function automatic logic [ROW_W-1:0] row_sel(input logic [QUAL_W-1:0] q);
		logic [QUAL_W-1:0] r;
		r = q - 4'd1;
		if (q == '0) begin
			r = '0;
		end else if (q > 4'd8) begin
			r = 4'd7;
		end
		return r[ROW_W-1:0];
	endfunction

	// ceil(2*(range+1) / 2^e), zero when the position has no levels
	function automatic logic [STEP_W-1:0] ac_step(input logic [RANGE_W-1:0] range,
			input lexp_t e);
		logic [STEP_W:0] num;
		logic [STEP_W:0] sh;
		num = ({2'b00, range} << 1) + 13'd2 + ((13'd1 << e) - 13'd1);
		sh  = num >> e;
		return (e == '0) ? '0 : sh[STEP_W-1:0];
	endfunction

endpackage

// File: hw/rtl/dctq_if.sv
// ---------------------------------------------------------------------------
// dctq_in_if / dctq_out_if
// Valid/ready channels for coefficient beats in and quantized beats out.
// ---------------------------------------------------------------------------
interface dctq_in_if import dctq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic [POS_W-1:0]          position;
	logic signed [COEF_W-1:0]  coefficient;
	logic [RANGE_W-1:0]        ac_range;
	logic [SHIFT_W-1:0]        level_shift;

	modport source (output valid, action, position, coefficient, ac_range, level_shift,
		input ready);
	modport sink (input valid, action, position, coefficient, ac_range, level_shift,
		output ready);
endinterface

interface dctq_out_if import dctq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [QUANT_W-1:0] quantized;

	modport source (output valid, quantized, input ready);
	modport sink (input valid, quantized, output ready);
endinterface

// File: hw/rtl/dctq_ram.sv
// ---------------------------------------------------------------------------
// dctq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dctq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/dctq_div.sv
// ---------------------------------------------------------------------------
// dctq_div
// Pipelined restoring divider, DIV_BITS (three) quotient bits per stage.
// ---------------------------------------------------------------------------
module dctq_div import dctq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [STEP_W-1:0] dividend,
	input  logic [STEP_W-1:0] divisor,
	input  div_side_t         in_side,
	output logic              out_valid,
	output logic [STEP_W-1:0] quotient,
	output div_side_t         out_side
);

	logic [DIV_STAGES-1:0] vld_q;
	div_state_t            st_q   [DIV_STAGES];
	div_side_t             side_q [DIV_STAGES];
	div_state_t            st_init;

	// run DIV_BITS restoring steps
	function automatic div_state_t div_iter(input div_state_t s);
		div_state_t   r;
		logic [STEP_W:0] trial;
		r = s;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {r.rem, r.dvd[STEP_W-1]};
			r.dvd = r.dvd << 1;
			if (trial >= {1'b0, r.dsr}) begin
				trial = trial - {1'b0, r.dsr};
				r.quo = {r.quo[STEP_W-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[STEP_W-2:0], 1'b0};
			end
			r.rem = trial[STEP_W-1:0];
		end
		return r;
	endfunction

	assign st_init = '{rem: '0, dvd: dividend, quo: '0, dsr: divisor};

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DIV_STAGES-2:0], in_valid};
		end
	end

	// advance stage payloads
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					st_q[g]   <= div_iter(st_init);
					side_q[g] <= in_side;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (en) begin
					st_q[g]   <= div_iter(st_q[g-1]);
					side_q[g] <= side_q[g-1];
				end
			end
		end
	end

	assign out_valid = vld_q[DIV_STAGES-1];
	assign quotient  = st_q[DIV_STAGES-1].quo;
	assign out_side  = side_q[DIV_STAGES-1];

endmodule

// File: hw/rtl/dct_coefficient_quantizer_4x4_core.sv
// Path: a quantize beat runs stage 1 (RAM read), stage 2, divider, output register.
// Throughput: one beat per cycle unless the output stalls, set by the 4-stage
// divider and the two-port step/shift RAM (one write and one read per cycle).
// Load beats give no result. Reset: quality index 1, pipeline empty; step/shift RAM
// content is undefined until loaded, and no clearing pass runs.
// ---------------------------------------------------------------------------
// dct_coefficient_quantizer_4x4_core
// Quantizes 4x4 transform coefficients with per-position steps kept in RAM.
// ---------------------------------------------------------------------------
`include "dct_coefficient_quantizer_4x4_core_assert.svh"

module dct_coefficient_quantizer_4x4_core import dctq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [QUAL_W-1:0] cfg_wdata,
	dctq_in_if.sink           in_ch,
	dctq_out_if.source        out_ch
);

	logic [QUAL_W-1:0]         quality_q;
	logic                      adv;
	logic                      in_acc;
	logic [ROW_W-1:0]          row;
	lexp_t                     lexp;
	entry_t                    wr_entry;
	entry_t                    rd_entry;

	logic                      vld_s1;
	logic                      dc_s1;
	logic [STEP_W-1:0]         dcdiv_s1;
	logic signed [COEF_W-1:0]  coef_s1;

	logic                      vld_s2;
	logic [STEP_W-1:0]         mag_s2;
	logic [STEP_W-1:0]         dsr_s2;
	div_side_t                 side_s2;

	logic                      dv_valid;
	logic [STEP_W-1:0]         dv_quo;
	div_side_t                 dv_side;

	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   sat;
	logic                      out_valid_q;
	logic signed [QUANT_W-1:0] quant_q;

	// hold quality index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quality_q <= QUAL_RESET;
		end else if (cfg_we) begin
			quality_q <= cfg_wdata;
		end
	end

	// whole pipeline moves unless the output beat is stalled
	assign adv         = !out_valid_q || out_ch.ready;
	assign in_ch.ready = adv;
	assign in_acc      = in_ch.valid && adv;

	assign row      = row_sel(quality_q);
	assign lexp     = LEVEL_EXP[row][in_ch.position];
	assign wr_entry = '{step: ac_step(in_ch.ac_range, lexp), shift: in_ch.level_shift};

	// step/shift store: loads write, quantizes read
	dctq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (NPOS)
	) u_ram (
		.clk   (clk),
		.we    (in_acc && in_ch.action == ACT_LOAD),
		.waddr (in_ch.position),
		.wdata (wr_entry),
		.re    (in_acc && in_ch.action == ACT_QUANT),
		.raddr (in_ch.position),
		.rdata (rd_entry)
	);

	// stage 1: capture beat while the RAM read is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_acc && in_ch.action == ACT_QUANT;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dc_s1    <= in_ch.position == '0;
			dcdiv_s1 <= DC_SPAN >> lexp;
			coef_s1  <= in_ch.coefficient;
		end
	end

	// stage 2: magnitude, divisor and side data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2       <= coef_s1[COEF_W-1] ? STEP_W'(-coef_s1) : STEP_W'(coef_s1);
			dsr_s2       <= dc_s1 ? dcdiv_s1 : rd_entry.step;
			side_s2.neg  <= coef_s1[COEF_W-1];
			side_s2.zero <= !dc_s1 && rd_entry.step == '0;
			side_s2.add  <= dc_s1 ? '0 : rd_entry.shift;
		end
	end

	dctq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s2),
		.dividend  (mag_s2),
		.divisor   (dsr_s2),
		.in_side   (side_s2),
		.out_valid (dv_valid),
		.quotient  (dv_quo),
		.out_side  (dv_side)
	);

	// restore sign, add shift, saturate; result is zero when the position has no levels
	always_comb begin
		sum = dv_side.neg ? -$signed({2'b00, dv_quo}) : $signed({2'b00, dv_quo});
		sum = sum + $signed({{(SUM_W-SHIFT_W){1'b0}}, dv_side.add});
		priority if (dv_side.zero) begin
			sat = '0;
		end else if (sum > OUT_MAX) begin
			sat = OUT_MAX;
		end else if (sum < OUT_MIN) begin
			sat = OUT_MIN;
		end else begin
			sat = sum;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quant_q <= sat[QUANT_W-1:0];
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.quantized = quant_q;

	`DCTQ_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld_s1) && $stable(vld_s2), "pipeline moved during stall")
	`DCTQ_ASSERT_NEXT(a_load_silent, in_acc && in_ch.action == ACT_LOAD, !vld_s1, "load beat entered result path")
	`DCTQ_ASSERT_NOW(a_out_rise, $rose(out_valid_q), $past(adv), "output valid rose without advance")

endmodule
